[hw/rtl/lpd_pkg.sv]
`timescale 1ns / 1ps

package lpd_pkg;

	typedef logic [31:0] turn_t;

	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day_of_month;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} date_t;

	typedef struct packed {
		logic [2:0]  phase_code;
		logic [14:0] illumination;
		logic [14:0] moon_age;
		logic [3:0]  zodiac_index;
		logic [15:0] moon_longitude;
	} phase_t;

	// phase codes
	localparam logic [2:0] PH_NEW             = 3'd0;
	localparam logic [2:0] PH_WAXING_CRESCENT = 3'd1;
	localparam logic [2:0] PH_FIRST_QUARTER   = 3'd2;
	localparam logic [2:0] PH_WAXING_GIBBOUS  = 3'd3;
	localparam logic [2:0] PH_FULL            = 3'd4;
	localparam logic [2:0] PH_WANING_GIBBOUS  = 3'd5;
	localparam logic [2:0] PH_LAST_QUARTER    = 3'd6;
	localparam logic [2:0] PH_WANING_CRESCENT = 3'd7;

	// calendar
	localparam logic [11:0] YEAR_MIN   = 12'd1583;
	localparam logic [15:0] YDIV_MUL   = 16'd41944;
	localparam logic [23:0] JD_OFFSET  = 24'd2453070;
	localparam logic [8:0]  MONTH_TERM [16] = '{
		9'd0, 9'd0, 9'd0, 9'd122, 9'd153, 9'd183, 9'd214, 9'd244,
		9'd275, 9'd306, 9'd336, 9'd367, 9'd397, 9'd428, 9'd459, 9'd0
	};

	// mean arguments: lp, d, m, m', f, solar longitude
	localparam int NUM_MEAN = 6;
	localparam int MI_LP = 0;
	localparam int MI_D  = 1;
	localparam int MI_MS = 2;
	localparam int MI_MP = 3;
	localparam int MI_F  = 4;
	localparam int MI_LS = 5;

	typedef turn_t [NUM_MEAN-1:0] mean_vec_t;

	localparam logic [127:0] RATE_DEN = 128'd11360736000000000;
	localparam logic [127:0] K_LP_W = {64'd4812678813, 64'd0} / RATE_DEN;
	localparam logic [127:0] K_D_W  = {64'd4452671114, 64'd0} / RATE_DEN;
	localparam logic [127:0] K_MS_W = {64'd359990503, 64'd0} / RATE_DEN;
	localparam logic [127:0] K_MP_W = {64'd4771988676, 64'd0} / RATE_DEN;
	localparam logic [127:0] K_F_W  = {64'd4832020175, 64'd0} / RATE_DEN;
	localparam logic [127:0] K_LS_W = {64'd360007698, 64'd0} / RATE_DEN;

	localparam logic [42:0] MEAN_K [NUM_MEAN] = '{
		K_LP_W[42:0], K_D_W[42:0], K_MS_W[42:0],
		K_MP_W[42:0], K_F_W[42:0], K_LS_W[42:0]
	};

	localparam logic [63:0] DEG_E4 = 64'd3600000;
	localparam logic [63:0] B_LP_W = {32'd2183165, 32'd0} / DEG_E4;
	localparam logic [63:0] B_D_W  = {32'd2978502, 32'd0} / DEG_E4;
	localparam logic [63:0] B_MS_W = {32'd3575291, 32'd0} / DEG_E4;
	localparam logic [63:0] B_MP_W = {32'd1349634, 32'd0} / DEG_E4;
	localparam logic [63:0] B_F_W  = {32'd932720, 32'd0} / DEG_E4;
	localparam logic [63:0] B_LS_W = {32'd2804665, 32'd0} / DEG_E4;

	localparam turn_t MEAN_BASE [NUM_MEAN] = '{
		B_LP_W[31:0], B_D_W[31:0], B_MS_W[31:0],
		B_MP_W[31:0], B_F_W[31:0], B_LS_W[31:0]
	};

	// periodic term coefficients, turn fractions
	localparam logic [63:0] C1_W = {32'd62890, 32'd0} / DEG_E4;
	localparam logic [63:0] C2_W = {32'd12740, 32'd0} / DEG_E4;
	localparam logic [63:0] C3_W = {32'd6580, 32'd0} / DEG_E4;
	localparam logic [63:0] C4_W = {32'd2140, 32'd0} / DEG_E4;
	localparam logic [63:0] C5_W = {32'd1860, 32'd0} / DEG_E4;
	localparam logic [63:0] C6_W = {32'd1140, 32'd0} / DEG_E4;
	localparam logic [63:0] CS1_W = {32'd19146, 32'd0} / DEG_E4;
	localparam logic [63:0] CS2_W = {32'd200, 32'd0} / DEG_E4;
	localparam logic [63:0] CS3_W = {32'd3, 32'd0} / DEG_E4;

	localparam logic signed [27:0] CM_MP = 28'(C1_W);
	localparam logic signed [27:0] CM_DM = 28'(C2_W);
	localparam logic signed [27:0] CM_2D = 28'(C3_W);
	localparam logic signed [27:0] CM_2M = 28'(C4_W);
	localparam logic signed [27:0] CM_MS = 28'(64'd0 - C5_W);
	localparam logic signed [27:0] CM_2F = 28'(64'd0 - C6_W);
	localparam logic signed [27:0] CS_MS = 28'(CS1_W);
	localparam logic signed [27:0] CS_2S = 28'(CS2_W);
	localparam logic signed [27:0] CS_3S = 28'(CS3_W);

	// sine arguments
	localparam int NUM_SIN = 8;
	localparam int SI_MP = 0;
	localparam int SI_DM = 1;
	localparam int SI_2D = 2;
	localparam int SI_2M = 3;
	localparam int SI_MS = 4;
	localparam int SI_2F = 5;
	localparam int SI_2S = 6;
	localparam int SI_3S = 7;

	// sine polynomial, Q30
	localparam logic [30:0] Q30 = 31'h4000_0000;
	localparam logic [30:0] SIN_A = 31'd1686629713;
	localparam logic [30:0] SIN_B = 31'd691031247;
	localparam logic [26:0] SIN_C = 27'd78143358;
	localparam turn_t QUARTER_TURN = 32'h4000_0000;

	// moon age
	localparam logic [40:0] AGE_EPOCH_S = 41'd440640;
	localparam logic [40:0] AGE_SHIFT_S = 41'd79732589409;
	localparam logic [41:0] SYN_US      = 42'd2551442861088;
	localparam logic [19:0] US_PER_S    = 20'd1000000;
	localparam logic [109:0] AGE_RQ_W   = {64'd1000000, 46'd0} / 110'd2551442861088;
	localparam logic [24:0] AGE_RQ      = AGE_RQ_W[24:0];
	localparam logic [26:0] AGE_UNIT_US = 27'd84375000;
	localparam logic [50:0] AGE_R2_W    = {1'b1, 50'd0} / 51'd84375000;
	localparam logic [23:0] AGE_R2      = AGE_R2_W[23:0];
	localparam logic [41:0] HUNDREDTH_US = 42'd864000000;
	localparam logic [41:0] PHASE_LIMIT [7] = '{
		42'd100 * HUNDREDTH_US, 42'd738 * HUNDREDTH_US, 42'd838 * HUNDREDTH_US,
		42'd1477 * HUNDREDTH_US, 42'd1577 * HUNDREDTH_US, 42'd2215 * HUNDREDTH_US,
		42'd2315 * HUNDREDTH_US
	};

	localparam logic [14:0] AGE_ONE_DAY = 15'd1024;
	localparam logic [14:0] AGE_MAX     = 15'd30240;
	localparam logic [14:0] ILLUM_MAX   = 15'd25600;
	localparam logic [3:0]  ZODIAC_MAX  = 4'd11;

endpackage

[hw/rtl/lunar_phase_from_date_unit.sv]
// lunar phase from a Gregorian date and time
//
// date channel: date_valid / date_stall with the date struct (year, month,
// day, hour, minute, second). an item is taken at a clock edge with
// date_valid high and date_stall low.
// phase channel: phase_valid / phase_stall with the phase struct (phase
// code, illumination, moon age, zodiac sign, moon longitude).
//
// every date gives exactly one phase item, which appears with phase_valid high
// at the last register stage and is taken at an edge with phase_stall low.
// the pipeline takes one date per cycle unless stalled; the 19 register stages
// are set by the date and mean argument stages, two five-stage sine polynomial
// units in series and the coefficient and illumination multipliers.
// while phase_valid is high and phase_stall is high the whole pipeline holds
// and date_stall is raised; nothing is dropped or repeated.
// reset empties the pipeline at once; there is no other state.
// SINE_TABLE_BITS sets the angle resolution fed to the sine polynomial.
`timescale 1ns / 1ps

module lunar_phase_from_date_unit #(
	parameter int SINE_TABLE_BITS = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             date_valid,
	output logic             date_stall,
	input  lpd_pkg::date_t   date,
	output logic             phase_valid,
	input  logic             phase_stall,
	output lpd_pkg::phase_t  phase
);
	import lpd_pkg::*;

	localparam int LAT = 19;

	logic [LAT:1] vld_q;
	logic         en;

	logic signed [39:0] secs_s3;
	mean_vec_t          mean_s5;
	turn_t              sin_ang [NUM_SIN];
	logic signed [31:0] sin_s10 [NUM_SIN];

	turn_t lp_dly_q [6];
	turn_t ls_dly_q [6];

	logic signed [59:0] pm_s11 [6];
	logic signed [59:0] ps_s11 [3];
	logic signed [63:0] sum_m, sum_s;
	turn_t              lmoon_s12, lsun_s12;
	turn_t              cos_ang;
	logic signed [31:0] cos_s17;
	logic [35:0]        lm12;

	logic [3:0]  zod_dly_q [6];
	logic [15:0] lon_dly_q [6];

	logic [14:0] age_s11;
	logic [2:0]  code_s11;
	logic [14:0] age_dly_q [7];
	logic [2:0]  code_dly_q [7];

	logic signed [33:0] cdiff;
	logic [45:0]        ill_s18;
	logic [45:0]        ill_rnd;
	phase_t             phase_s19;

	assign en          = !(vld_q[LAT] && phase_stall);
	assign date_stall  = vld_q[LAT] && phase_stall;
	assign phase_valid = vld_q[LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-1:1], date_valid};
		end
	end

	lpd_date u_date (
		.clk     (clk),
		.en      (en),
		.date    (date),
		.secs_s3 (secs_s3),
		.mean_s5 (mean_s5)
	);

	lpd_age u_age (
		.clk      (clk),
		.en       (en),
		.secs_s3  (secs_s3),
		.age_s11  (age_s11),
		.code_s11 (code_s11)
	);

	always_comb begin
		sin_ang[SI_MP] = mean_s5[MI_MP];
		sin_ang[SI_DM] = (mean_s5[MI_D] << 1) - mean_s5[MI_MP];
		sin_ang[SI_2D] = mean_s5[MI_D] << 1;
		sin_ang[SI_2M] = mean_s5[MI_MP] << 1;
		sin_ang[SI_MS] = mean_s5[MI_MS];
		sin_ang[SI_2F] = mean_s5[MI_F] << 1;
		sin_ang[SI_2S] = mean_s5[MI_MS] << 1;
		sin_ang[SI_3S] = (mean_s5[MI_MS] << 1) + mean_s5[MI_MS];
	end

	for (genvar i = 0; i < NUM_SIN; i++) begin : g_sin
		lpd_sine #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_sin (
			.clk     (clk),
			.en      (en),
			.ang     (sin_ang[i]),
			.sin_val (sin_s10[i])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lp_dly_q[0] <= mean_s5[MI_LP];
			ls_dly_q[0] <= mean_s5[MI_LS];
			for (int k = 1; k < 6; k++) begin
				lp_dly_q[k] <= lp_dly_q[k-1];
				ls_dly_q[k] <= ls_dly_q[k-1];
			end

			pm_s11[0] <= CM_MP * sin_s10[SI_MP];
			pm_s11[1] <= CM_DM * sin_s10[SI_DM];
			pm_s11[2] <= CM_2D * sin_s10[SI_2D];
			pm_s11[3] <= CM_2M * sin_s10[SI_2M];
			pm_s11[4] <= CM_MS * sin_s10[SI_MS];
			pm_s11[5] <= CM_2F * sin_s10[SI_2F];
			ps_s11[0] <= CS_MS * sin_s10[SI_MS];
			ps_s11[1] <= CS_2S * sin_s10[SI_2S];
			ps_s11[2] <= CS_3S * sin_s10[SI_3S];
		end
	end

	assign sum_m = 64'(pm_s11[0]) + 64'(pm_s11[1]) + 64'(pm_s11[2])
		+ 64'(pm_s11[3]) + 64'(pm_s11[4]) + 64'(pm_s11[5]);
	assign sum_s = 64'(ps_s11[0]) + 64'(ps_s11[1]) + 64'(ps_s11[2]);

	// Q62 sums floored to turn units
	always_ff @(posedge clk) begin
		if (en) begin
			lmoon_s12 <= lp_dly_q[5] + sum_m[61:30];
			lsun_s12  <= ls_dly_q[5] + sum_s[61:30];
		end
	end

	// cosine of the elongation
	assign cos_ang = lmoon_s12 - lsun_s12 + QUARTER_TURN;

	lpd_sine #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_cos (
		.clk     (clk),
		.en      (en),
		.ang     (cos_ang),
		.sin_val (cos_s17)
	);

	assign lm12  = (36'(lmoon_s12) << 3) + (36'(lmoon_s12) << 2);
	assign cdiff = $signed(34'(Q30)) - 34'(cos_s17);
	assign ill_rnd = ill_s18 + 46'h2000_0000;

	always_ff @(posedge clk) begin
		if (en) begin
			zod_dly_q[0] <= lm12[35:32];
			lon_dly_q[0] <= lmoon_s12[31:16];
			for (int k = 1; k < 6; k++) begin
				zod_dly_q[k] <= zod_dly_q[k-1];
				lon_dly_q[k] <= lon_dly_q[k-1];
			end

			age_dly_q[0]  <= age_s11;
			code_dly_q[0] <= code_s11;
			for (int k = 1; k < 7; k++) begin
				age_dly_q[k]  <= age_dly_q[k-1];
				code_dly_q[k] <= code_dly_q[k-1];
			end

			ill_s18 <= 46'd12800 * 46'(cdiff[32:0]);

			phase_s19.phase_code     <= code_dly_q[6];
			phase_s19.illumination   <= ill_rnd[44:30];
			phase_s19.moon_age       <= age_dly_q[6];
			phase_s19.zodiac_index   <= zod_dly_q[5];
			phase_s19.moon_longitude <= lon_dly_q[5];
		end
	end

	assign phase = phase_s19;

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_valid |-> phase.illumination <= ILLUM_MAX)
		else $error("illumination above full");

	assert property (@(posedge clk) disable iff (!arst_n)
		phase_valid |-> phase.zodiac_index <= ZODIAC_MAX)
		else $error("zodiac index out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		phase_valid |-> phase.moon_age < AGE_MAX)
		else $error("moon age beyond one synodic month");

	assert property (@(posedge clk) disable iff (!arst_n)
		phase_valid |-> ((phase.phase_code == PH_NEW) == (phase.moon_age < AGE_ONE_DAY)))
		else $error("new moon code does not match age");
`endif

endmodule

[hw/rtl/lpd_sine.sv]
`timescale 1ns / 1ps

module lpd_sine #(
	parameter int SINE_TABLE_BITS = 10
) (
	input  logic                clk,
	input  logic                en,
	input  lpd_pkg::turn_t      ang,
	output logic signed [31:0]  sin_val
);
	import lpd_pkg::*;

	localparam int DROP = 32 - SINE_TABLE_BITS;
	localparam logic [29:0] FRAC_MASK = ~30'((64'd1 << DROP) - 64'd1);

	logic [29:0] zm;
	logic [30:0] z_in;
	logic [61:0] zz;
	logic [57:0] z2c;
	logic [61:0] z2t;
	logic [61:0] zt;

	logic [30:0] z_s1, z_s2, z_s3, z_s4;
	logic        neg_s1, neg_s2, neg_s3, neg_s4;
	logic [30:0] z2_s2, z2_s3;
	logic [30:0] t1_s3;
	logic [30:0] t2_s4;
	logic signed [31:0] v_s5;

	// angle cut to the table resolution, folded into the first quadrant
	assign zm   = ang[29:0] & FRAC_MASK;
	assign z_in = ang[30] ? (Q30 - {1'b0, zm}) : {1'b0, zm};

	assign zz  = z_s1 * z_s1;
	assign z2c = z2_s2 * SIN_C;
	assign z2t = z2_s3 * t1_s3;
	assign zt  = z_s4 * t2_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			z_s1   <= z_in;
			neg_s1 <= ang[31];

			z2_s2  <= zz[60:30];
			z_s2   <= z_s1;
			neg_s2 <= neg_s1;

			t1_s3  <= SIN_B - 31'(z2c[57:30]);
			z2_s3  <= z2_s2;
			z_s3   <= z_s2;
			neg_s3 <= neg_s2;

			t2_s4  <= SIN_A - z2t[60:30];
			z_s4   <= z_s3;
			neg_s4 <= neg_s3;

			v_s5   <= neg_s4 ? -$signed(zt[61:30]) : $signed(zt[61:30]);
		end
	end

	assign sin_val = v_s5;

endmodule

[hw/rtl/lpd_date.sv]
`timescale 1ns / 1ps

module lpd_date (
	input  logic                clk,
	input  logic                en,
	input  lpd_pkg::date_t      date,
	output logic signed [39:0]  secs_s3,
	output lpd_pkg::mean_vec_t  mean_s5
);
	import lpd_pkg::*;

	logic [11:0] yc, yadj;
	logic [3:0]  mc, madj;
	logic [27:0] ydiv;

	logic [11:0] yr_s1;
	logic [5:0]  cent_s1;
	logic [3:0]  mon_s1;
	logic [4:0]  day_s1;
	logic [16:0] tod_s1;

	logic [23:0] ysum, yterm, jdw;
	logic signed [20:0] jd_s2;
	logic [16:0] tod_s2;

	// clamp, and January/February count as months 13/14 of the year before
	always_comb begin
		yc = (date.year < YEAR_MIN) ? YEAR_MIN : date.year;
		if (date.month == 4'd0) begin
			mc = 4'd1;
		end else if (date.month > 4'd12) begin
			mc = 4'd12;
		end else begin
			mc = date.month;
		end
		if (mc <= 4'd2) begin
			yadj = yc - 12'd1;
			madj = mc + 4'd12;
		end else begin
			yadj = yc;
			madj = mc;
		end
		ydiv = 28'(yadj) * 28'(YDIV_MUL);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			yr_s1   <= yadj;
			cent_s1 <= ydiv[27:22];
			mon_s1  <= madj;
			day_s1  <= date.day_of_month;
			tod_s1  <= 17'(date.hour) * 17'd3600 + 17'(date.minute) * 17'd60
				+ 17'(date.second);
		end
	end

	always_comb begin
		ysum  = 24'(yr_s1) + 24'd4716;
		yterm = ysum * 24'd1461;
		jdw   = 24'(yterm[23:2]) + 24'(MONTH_TERM[mon_s1]) + 24'(day_s1) + 24'd2
			- 24'(cent_s1) + 24'(cent_s1[5:2]) - JD_OFFSET;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			jd_s2  <= jdw[20:0];
			tod_s2 <= tod_s1;
			secs_s3 <= 40'(jd_s2) * 40'sd86400 + 40'sd43200 + $signed({23'd0, tod_s2});
		end
	end

	// mean arguments: low 64 bits of secs * rate, split in four partial products
	for (genvar g = 0; g < NUM_MEAN; g++) begin : g_mean
		logic [41:0]        pp0_s4;
		logic [40:0]        pp1_s4;
		logic signed [42:0] pp2_s4;
		logic signed [41:0] pp3_s4;
		logic [63:0]        tot;

		always_ff @(posedge clk) begin
			if (en) begin
				pp0_s4 <= secs_s3[19:0] * MEAN_K[g][21:0];
				pp1_s4 <= secs_s3[19:0] * MEAN_K[g][42:22];
				pp2_s4 <= $signed(secs_s3[39:20]) * $signed({1'b0, MEAN_K[g][21:0]});
				pp3_s4 <= $signed(secs_s3[39:20]) * $signed({1'b0, MEAN_K[g][42:22]});
			end
		end

		assign tot = 64'(pp0_s4) + (64'(pp1_s4) << 22) + (64'(pp2_s4) << 20)
			+ (64'(pp3_s4) << 42);

		always_ff @(posedge clk) begin
			if (en) begin
				mean_s5[g] <= tot[63:32] + MEAN_BASE[g];
			end
		end
	end

endmodule

[hw/rtl/lpd_age.sv]
`timescale 1ns / 1ps

module lpd_age (
	input  logic               clk,
	input  logic               en,
	input  logic signed [39:0] secs_s3,
	output logic [14:0]        age_s11,
	output logic [2:0]         code_s11
);
	import lpd_pkg::*;

	logic [40:0] uw;
	logic [57:0] qsyn;
	logic [57:0] r0w;
	logic [55:0] p2w;
	logic [41:0] aus;
	logic [41:0] rem;
	logic [2:0]  code_c;

	logic [37:0] u_s4;
	logic [57:0] xus_s5, xus_s6;
	logic [56:0] qp_s5;
	logic [16:0] qest_s6;
	logic [42:0] r0_s7;
	logic [41:0] r_s8, r_s9, r_s10;
	logic [55:0] p2_s9;
	logic [14:0] aest_s10;

	// shift by a whole number of synodic months so the value is never negative
	assign uw   = 41'(secs_s3) - AGE_EPOCH_S + AGE_SHIFT_S;
	assign qsyn = 58'(qest_s6) * 58'(SYN_US);
	assign r0w  = xus_s6 - qsyn;
	assign p2w  = r_s8[41:10] * AGE_R2;
	assign aus  = 42'(aest_s10) * 42'(AGE_UNIT_US);
	assign rem  = r_s10 - aus;

	always_comb begin
		code_c = PH_WANING_CRESCENT;
		priority if (r_s10 < PHASE_LIMIT[0]) code_c = PH_NEW;
		else if (r_s10 < PHASE_LIMIT[1]) code_c = PH_WAXING_CRESCENT;
		else if (r_s10 < PHASE_LIMIT[2]) code_c = PH_FIRST_QUARTER;
		else if (r_s10 < PHASE_LIMIT[3]) code_c = PH_WAXING_GIBBOUS;
		else if (r_s10 < PHASE_LIMIT[4]) code_c = PH_FULL;
		else if (r_s10 < PHASE_LIMIT[5]) code_c = PH_WANING_GIBBOUS;
		else if (r_s10 < PHASE_LIMIT[6]) code_c = PH_LAST_QUARTER;
		else code_c = PH_WANING_CRESCENT;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s4 <= uw[37:0];

			xus_s5 <= 58'(u_s4) * 58'(US_PER_S);
			qp_s5  <= u_s4[37:6] * AGE_RQ;

			// quotient estimate is exact or one short
			qest_s6 <= qp_s5[56:40];
			xus_s6  <= xus_s5;

			r0_s7 <= r0w[42:0];

			r_s8 <= (r0_s7 >= 43'(SYN_US)) ? 42'(r0_s7 - 43'(SYN_US)) : r0_s7[41:0];

			p2_s9 <= p2w;
			r_s9  <= r_s8;

			aest_s10 <= p2_s9[54:40];
			r_s10    <= r_s9;

			age_s11  <= (rem >= 42'(AGE_UNIT_US)) ? aest_s10 + 15'd1 : aest_s10;
			code_s11 <= code_c;
		end
	end

endmodule
